FILE: hdl/mcuf_pkg.sv
// ----------------------------------------------------------------------------
// mcuf_pkg
// Shared types, codes and constants of the union-find maze cell carver.
// ----------------------------------------------------------------------------
package mcuf_pkg;

   localparam int MAX_DIM_DEFAULT = 32;

   localparam int COORD_W    = 5;
   localparam int OUTCOME_W  = 3;
   localparam int REMAIN_W   = 16;
   localparam int CSR_INDEX_W = 2;

   localparam logic [COORD_W-1:0] SIZE_RESET = 5'd7;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Z = 2'd2;

   typedef logic [OUTCOME_W-1:0] outcome_type;

   localparam outcome_type OUTCOME_CHECKED     = 3'd0;
   localparam outcome_type OUTCOME_SPACE       = 3'd1;
   localparam outcome_type OUTCOME_WALL_OPENED = 3'd2;
   localparam outcome_type OUTCOME_WALL_KEPT   = 3'd3;
   localparam outcome_type OUTCOME_SOLID       = 3'd4;
   localparam outcome_type OUTCOME_RANGE       = 3'd5;

   // per-cell flags; all zero means unchecked, solid, no parent
   typedef struct packed {
      logic has_parent;
      logic open;
      logic checked;
   } flags_type;

   localparam int FLAGS_W = $bits(flags_type);

   // cell store read address selection
   typedef logic [1:0] rd_sel_type;
   localparam rd_sel_type RD_CELL   = 2'd0;
   localparam rd_sel_type RD_NEAR   = 2'd1;
   localparam rd_sel_type RD_FAR    = 2'd2;
   localparam rd_sel_type RD_PARENT = 2'd3;

   // cell store write selection
   typedef logic [2:0] wr_sel_type;
   localparam wr_sel_type WR_NONE      = 3'd0;
   localparam wr_sel_type WR_CLEAR     = 3'd1;
   localparam wr_sel_type WR_CELL_KEPT = 3'd2;
   localparam wr_sel_type WR_CELL_OPEN = 3'd3;
   localparam wr_sel_type WR_LINK      = 3'd4;

   typedef struct packed {
      logic        load_req;
      rd_sel_type  rd_sel;
      logic        track;
      logic        save_cell;
      logic        save_root1;
      logic        save_root2;
      wr_sel_type  wr_sel;
      logic        set_result;
      outcome_type outcome;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic out_range;
      logic checked;
      logic is_space;
      logic is_wall;
      logic link_next;
      logic roots_differ;
      logic rsp_free;
   } status_type;

endpackage

FILE: hdl/maze_cell_union_find_carver_core.sv
// ----------------------------------------------------------------------------
// maze_cell_union_find_carver_core
// Carves a 3-D maze one picked cell per request, joining rooms by union-find.
// ----------------------------------------------------------------------------
// Sequence: a request is registered on accept and bounds-checked; in range, its
//   cell flags are read and classified; a wall walks the parent links from the
//   near and then the far side, and opens only if the two roots differ.
// Throughput: one request at a time, set by the chain walks, which issue one
//   cell store read per cycle through its single registered read port.
// Reset: synchronous; a clearing pass then sweeps all MAX_DIM^3 entries (32768
//   by default) of the cell flag store, one entry per cycle, with req_stall high.
// ----------------------------------------------------------------------------
module maze_cell_union_find_carver_core #(
   parameter int MAX_DIM = mcuf_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mcuf_pkg::COORD_W-1:0]     req_pos_x,
   input  logic [mcuf_pkg::COORD_W-1:0]     req_pos_y,
   input  logic [mcuf_pkg::COORD_W-1:0]     req_pos_z,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mcuf_pkg::OUTCOME_W-1:0]   rsp_outcome,
   output logic                             rsp_cell_open,
   output logic [mcuf_pkg::REMAIN_W-1:0]    rsp_remaining,
   // configuration write channel
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mcuf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mcuf_pkg::COORD_W-1:0]     csr_wdata
);
   import mcuf_pkg::*;

   cmd_type    cmd;
   status_type status;

   // size registers take a write in any cycle
   assign csr_ready = 1'b1;

   // sequencer: hold requests off during the clearing pass and while busy
   mcuf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // cell store, walk pointers, checked count and result register
   mcuf_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_outcome   (rsp_outcome),
      .rsp_cell_open (rsp_cell_open),
      .rsp_remaining (rsp_remaining)
   );

endmodule

FILE: hdl/mcuf_ram.sv
// ----------------------------------------------------------------------------
// mcuf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mcuf_ram #(
   parameter  int WIDTH  = 1,
   parameter  int DEPTH  = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/mcuf_ctrl.sv
// ----------------------------------------------------------------------------
// mcuf_ctrl
// Sequencer of the carver: clearing pass, lookup, chain walks, link, result.
// ----------------------------------------------------------------------------
module mcuf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mcuf_pkg::status_type status,
   output mcuf_pkg::cmd_type    cmd
);
   import mcuf_pkg::*;

   localparam logic [3:0] S_CLEAR     = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_LOOKUP    = 4'd2;
   localparam logic [3:0] S_CLASSIFY  = 4'd3;
   localparam logic [3:0] S_WALK1     = 4'd4;
   localparam logic [3:0] S_WALK2     = 4'd5;
   localparam logic [3:0] S_JOIN      = 4'd6;
   localparam logic [3:0] S_OPEN_WALL = 4'd7;
   localparam logic [3:0] S_FINISH    = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_CLEAR: begin
            cmd.wr_sel = WR_CLEAR;
            if (status.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            if (status.out_range) begin
               cmd.set_result = 1'b1;
               cmd.outcome    = OUTCOME_RANGE;
               state_in       = S_FINISH;
            end else begin
               cmd.rd_sel = RD_CELL;
               state_in   = S_CLASSIFY;
            end
         end
         S_CLASSIFY: begin
            cmd.save_cell = 1'b1;
            if (status.checked) begin
               cmd.set_result = 1'b1;
               cmd.outcome    = OUTCOME_CHECKED;
               state_in       = S_FINISH;
            end else if (status.is_space) begin
               cmd.wr_sel     = WR_CELL_OPEN;
               cmd.set_result = 1'b1;
               cmd.outcome    = OUTCOME_SPACE;
               state_in       = S_FINISH;
            end else if (status.is_wall) begin
               cmd.rd_sel = RD_NEAR;
               cmd.track  = 1'b1;
               state_in   = S_WALK1;
            end else begin
               cmd.wr_sel     = WR_CELL_KEPT;
               cmd.set_result = 1'b1;
               cmd.outcome    = OUTCOME_SOLID;
               state_in       = S_FINISH;
            end
         end
         S_WALK1: begin
            cmd.track = 1'b1;
            if (status.link_next) begin
               cmd.rd_sel = RD_PARENT;
            end else begin
               cmd.save_root1 = 1'b1;
               cmd.rd_sel     = RD_FAR;
               state_in       = S_WALK2;
            end
         end
         S_WALK2: begin
            if (status.link_next) begin
               cmd.track  = 1'b1;
               cmd.rd_sel = RD_PARENT;
            end else begin
               cmd.save_root2 = 1'b1;
               state_in       = S_JOIN;
            end
         end
         S_JOIN: begin
            if (status.roots_differ) begin
               cmd.wr_sel = WR_LINK;
               state_in   = S_OPEN_WALL;
            end else begin
               cmd.wr_sel     = WR_CELL_KEPT;
               cmd.set_result = 1'b1;
               cmd.outcome    = OUTCOME_WALL_KEPT;
               state_in       = S_FINISH;
            end
         end
         S_OPEN_WALL: begin
            cmd.wr_sel     = WR_CELL_OPEN;
            cmd.set_result = 1'b1;
            cmd.outcome    = OUTCOME_WALL_OPENED;
            state_in       = S_FINISH;
         end
         S_FINISH: begin
            if (status.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/mcuf_datapath.sv
// ----------------------------------------------------------------------------
// mcuf_datapath
// Size registers, cell store, chain walk pointers, checked count and result.
// ----------------------------------------------------------------------------
module mcuf_datapath #(
   parameter int MAX_DIM = mcuf_pkg::MAX_DIM_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [mcuf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mcuf_pkg::COORD_W-1:0]         csr_wdata,
   input  logic [mcuf_pkg::COORD_W-1:0]         req_pos_x,
   input  logic [mcuf_pkg::COORD_W-1:0]         req_pos_y,
   input  logic [mcuf_pkg::COORD_W-1:0]         req_pos_z,
   input  logic                                 rsp_stall,
   input  mcuf_pkg::cmd_type                    cmd,
   output mcuf_pkg::status_type                 status,
   output logic                                 rsp_valid,
   output logic [mcuf_pkg::OUTCOME_W-1:0]       rsp_outcome,
   output logic                                 rsp_cell_open,
   output logic [mcuf_pkg::REMAIN_W-1:0]        rsp_remaining
);
   import mcuf_pkg::*;

   localparam int CELLS    = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int IDX_W    = $clog2(CELLS);
   localparam int STRIDE_X = MAX_DIM * MAX_DIM;
   localparam int STRIDE_Y = MAX_DIM;
   localparam int STRIDE_Z = 1;
   localparam int SXY_W    = 2 * COORD_W;
   localparam int TOTAL_W  = 3 * COORD_W;
   localparam logic [IDX_W:0]   CELL_LIMIT = (IDX_W + 1)'(CELLS);
   localparam logic [IDX_W-1:0] CLEAR_END  = IDX_W'(CELLS - 1);

   function automatic logic [COORD_W-1:0] clamp_dim(input logic [COORD_W-1:0] s);
      return (int'(s) > MAX_DIM) ? COORD_W'(MAX_DIM) : s;
   endfunction

   logic [COORD_W-1:0] size_x_ff, size_y_ff, size_z_ff;
   logic [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic [SXY_W-1:0]   sxy_ff;
   flags_type          cell_flags_ff;
   flags_type          root1_flags_ff;
   logic [IDX_W-1:0]   cur_ff, root1_ff, root2_ff;
   logic [IDX_W-1:0]   clear_addr_ff;
   logic [REMAIN_W-1:0] checked_total_ff;
   outcome_type        outcome_ff;
   logic               open_ff;
   logic               rsp_valid_ff;
   outcome_type        rsp_outcome_ff;
   logic               rsp_cell_open_ff;
   logic [REMAIN_W-1:0] rsp_remaining_ff;

   logic [COORD_W-1:0] sx, sy, sz;
   logic               ox, oy, oz;
   logic [1:0]         evens;
   logic               interior_wall;
   logic [IDX_W-1:0]   cell_idx, stride, near_idx, far_idx;
   logic [IDX_W-1:0]   rd_addr, parent_rd;
   logic [FLAGS_W-1:0] flags_rd_raw;
   flags_type          rd_flags, cell_now, flags_wr_data;
   logic               flags_wr_en, parent_wr_en;
   logic [IDX_W-1:0]   flags_wr_addr;
   logic               count_inc;
   logic               open_in;
   logic [TOTAL_W-1:0] total;
   logic [REMAIN_W-1:0] total_ext, remaining_in;

   // sizes in use and cell decoding
   assign sx = clamp_dim(size_x_ff);
   assign sy = clamp_dim(size_y_ff);
   assign sz = clamp_dim(size_z_ff);

   assign ox = pos_x_ff[0];
   assign oy = pos_y_ff[0];
   assign oz = pos_z_ff[0];
   assign evens = 2'(!ox) + 2'(!oy) + 2'(!oz);

   assign interior_wall = (pos_x_ff != '0) && (pos_y_ff != '0) && (pos_z_ff != '0)
      && ({1'b0, pos_x_ff} + 6'd1 < {1'b0, sx})
      && ({1'b0, pos_y_ff} + 6'd1 < {1'b0, sy})
      && ({1'b0, pos_z_ff} + 6'd1 < {1'b0, sz});

   assign cell_idx = IDX_W'(int'(pos_x_ff) * STRIDE_X + int'(pos_y_ff) * STRIDE_Y
                            + int'(pos_z_ff));
   assign stride   = !ox ? IDX_W'(STRIDE_X) : (!oy ? IDX_W'(STRIDE_Y) : IDX_W'(STRIDE_Z));
   assign near_idx = cell_idx - stride;
   assign far_idx  = cell_idx + stride;

   assign rd_flags = flags_type'(flags_rd_raw);
   assign cell_now = cmd.save_cell ? rd_flags : cell_flags_ff;

   always_comb begin
      case (cmd.rd_sel)
         RD_CELL:   rd_addr = cell_idx;
         RD_NEAR:   rd_addr = near_idx;
         RD_FAR:    rd_addr = far_idx;
         RD_PARENT: rd_addr = parent_rd;
         default:   rd_addr = cell_idx;
      endcase
   end

   always_comb begin
      flags_wr_en   = 1'b0;
      parent_wr_en  = 1'b0;
      flags_wr_addr = cell_idx;
      flags_wr_data = '0;
      count_inc     = 1'b0;
      case (cmd.wr_sel)
         WR_CLEAR: begin
            flags_wr_en   = 1'b1;
            flags_wr_addr = clear_addr_ff;
         end
         WR_CELL_KEPT: begin
            flags_wr_en   = 1'b1;
            flags_wr_data = '{has_parent: cell_now.has_parent, open: cell_now.open,
                              checked: 1'b1};
            count_inc     = 1'b1;
         end
         WR_CELL_OPEN: begin
            flags_wr_en   = 1'b1;
            flags_wr_data = '{has_parent: cell_now.has_parent, open: 1'b1,
                              checked: 1'b1};
            count_inc     = 1'b1;
         end
         WR_LINK: begin
            flags_wr_en   = 1'b1;
            parent_wr_en  = 1'b1;
            flags_wr_addr = root1_ff;
            flags_wr_data = '{has_parent: 1'b1, open: root1_flags_ff.open,
                              checked: root1_flags_ff.checked};
         end
         default: begin
            flags_wr_en = 1'b0;
         end
      endcase
   end

   mcuf_ram #(
      .WIDTH (FLAGS_W),
      .DEPTH (CELLS)
   ) u_flags_ram (
      .clock   (clock),
      .wr_en   (flags_wr_en),
      .wr_addr (flags_wr_addr),
      .wr_data (FLAGS_W'(flags_wr_data)),
      .rd_addr (rd_addr),
      .rd_data (flags_rd_raw)
   );

   mcuf_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CELLS)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (parent_wr_en),
      .wr_addr (root1_ff),
      .wr_data (root2_ff),
      .rd_addr (rd_addr),
      .rd_data (parent_rd)
   );

   // result open flag follows the outcome
   always_comb begin
      case (cmd.outcome)
         OUTCOME_RANGE:       open_in = 1'b0;
         OUTCOME_SPACE:       open_in = 1'b1;
         OUTCOME_WALL_OPENED: open_in = 1'b1;
         default:             open_in = cell_now.open;
      endcase
   end

   assign total        = TOTAL_W'(sxy_ff * sz);
   assign total_ext    = REMAIN_W'(total);
   assign remaining_in = (total_ext > checked_total_ff) ? total_ext - checked_total_ff : '0;

   assign status.clear_last   = (clear_addr_ff == CLEAR_END);
   assign status.out_range    = (pos_x_ff >= sx) || (pos_y_ff >= sy) || (pos_z_ff >= sz);
   assign status.checked      = rd_flags.checked;
   assign status.is_space     = (pos_x_ff != '0) && (pos_y_ff != '0) && (pos_z_ff != '0)
                                && (evens == 2'd0);
   assign status.is_wall      = interior_wall && (evens == 2'd1);
   assign status.link_next    = rd_flags.has_parent && ({1'b0, parent_rd} < CELL_LIMIT);
   assign status.roots_differ = (root1_ff != root2_ff);
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff        <= SIZE_RESET;
         size_y_ff        <= SIZE_RESET;
         size_z_ff        <= SIZE_RESET;
         clear_addr_ff    <= '0;
         checked_total_ff <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               REG_SIZE_X: size_x_ff <= csr_wdata;
               REG_SIZE_Y: size_y_ff <= csr_wdata;
               REG_SIZE_Z: size_z_ff <= csr_wdata;
               default:    size_x_ff <= size_x_ff;
            endcase
         end
         if (cmd.wr_sel == WR_CLEAR) begin
            clear_addr_ff <= clear_addr_ff + 1'b1;
         end
         if (count_inc && (checked_total_ff != '1)) begin
            checked_total_ff <= checked_total_ff + 1'b1;
         end
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      sxy_ff <= SXY_W'(sx * sy);
      if (cmd.load_req) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
      if (cmd.save_cell) begin
         cell_flags_ff <= rd_flags;
      end
      if (cmd.track) begin
         cur_ff <= rd_addr;
      end
      if (cmd.save_root1) begin
         root1_ff       <= cur_ff;
         root1_flags_ff <= rd_flags;
      end
      if (cmd.save_root2) begin
         root2_ff <= cur_ff;
      end
      if (cmd.set_result) begin
         outcome_ff <= cmd.outcome;
         open_ff    <= open_in;
      end
      if (cmd.load_rsp) begin
         rsp_outcome_ff   <= outcome_ff;
         rsp_cell_open_ff <= open_ff;
         rsp_remaining_ff <= remaining_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_outcome   = rsp_outcome_ff;
   assign rsp_cell_open = rsp_cell_open_ff;
   assign rsp_remaining = rsp_remaining_ff;

endmodule

FILE: tb/sv/maze_cell_union_find_carver_core_tb.sv
// ----------------------------------------------------------------------------
// maze_cell_union_find_carver_core_tb
// Self-checking bench for the union-find maze carver. A bit-accurate model of
// the cell store predicts every result; requests come from directed and
// random tests with random gaps and result back-pressure, and each result is
// compared field by field in arrival order.
// ----------------------------------------------------------------------------
module maze_cell_union_find_carver_core_tb;
   import mcuf_pkg::*;

   localparam int MAX_DIM        = MAX_DIM_DEFAULT;
   localparam int CELLS          = MAX_DIM * MAX_DIM * MAX_DIM;
   localparam int STEP_X         = MAX_DIM * MAX_DIM;
   localparam int STEP_Y         = MAX_DIM;
   localparam int STEP_Z         = 1;
   localparam int RESET_CYCLES   = 12;
   localparam int SETTLE_CYCLES  = 8;
   localparam int HOLD_CYCLES    = 400;
   localparam int REPORT_LIMIT   = 10;

   // index 3 decodes to no register; writes there must leave the sizes alone
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type             pick_x;
      coord_type             pick_y;
      coord_type             pick_z;
      outcome_type           outcome;
      logic                  cell_open;
      logic [REMAIN_W-1:0]   remaining;
   } carve_result_type;

   // -------------------------------------------------------------------------
   // clock, reset and block inputs, all known from time zero
   // -------------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid = 1'b0;
   logic                   req_stall;
   coord_type              req_pos_x = '0;
   coord_type              req_pos_y = '0;
   coord_type              req_pos_z = '0;

   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [OUTCOME_W-1:0]   rsp_outcome;
   logic                   rsp_cell_open;
   logic [REMAIN_W-1:0]    rsp_remaining;

   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   coord_type              csr_wdata = '0;

   // result back-pressure: random short bursts plus one long hold-off
   logic stall_burst = 1'b0;
   logic stall_hold  = 1'b0;
   int   burst_left  = 0;
   bit   req_idle_on = 1'b1;
   bit   rsp_idle_on = 1'b1;

   assign rsp_stall = stall_burst | stall_hold;

   always #1 clock = ~clock;

   maze_cell_union_find_carver_core #(
      .MAX_DIM       (MAX_DIM)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_pos_z     (req_pos_z),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_outcome   (rsp_outcome),
      .rsp_cell_open (rsp_cell_open),
      .rsp_remaining (rsp_remaining),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   // -------------------------------------------------------------------------
   // carver model: its own copy of the cell store and of the size registers
   // -------------------------------------------------------------------------
   bit        cell_checked [CELLS] = '{default: 1'b0};
   bit        cell_solid   [CELLS] = '{default: 1'b1};
   bit        cell_linked  [CELLS] = '{default: 1'b0};
   bit [14:0] cell_parent  [CELLS] = '{default: '0};
   int        checked_count = 0;
   coord_type cfg_size_x = SIZE_RESET;
   coord_type cfg_size_y = SIZE_RESET;
   coord_type cfg_size_z = SIZE_RESET;

   carve_result_type pending_results [$];
   int               fail_count = 0;

   // Follow parent links up to the root of a room's set; bound the walk by the
   // store size so a corrupt chain cannot hang the model.
   function automatic bit [14:0] chase_root(input bit [14:0] start);
      bit [14:0] node;
      node = start;
      for (int n = 0; n < CELLS; n++) begin
         if (!cell_linked[node]) break;
         node = cell_parent[node];
      end
      return node;
   endfunction

   // Apply one picked cell to the model store and return the result it owes.
   function automatic carve_result_type carve_predict(input coord_type x, y, z);
      carve_result_type r;
      int        sx, sy, sz, xi, yi, zi, total, evens, stride;
      bit        ox, oy, oz, wall_inside;
      bit [14:0] idx, root_near, root_far;
      sx = (cfg_size_x > MAX_DIM) ? MAX_DIM : cfg_size_x;
      sy = (cfg_size_y > MAX_DIM) ? MAX_DIM : cfg_size_y;
      sz = (cfg_size_z > MAX_DIM) ? MAX_DIM : cfg_size_z;
      xi = x;
      yi = y;
      zi = z;
      total = sx * sy * sz;
      r.pick_x = x;
      r.pick_y = y;
      r.pick_z = z;
      if (xi >= sx || yi >= sy || zi >= sz) begin
         r.outcome   = OUTCOME_RANGE;
         r.cell_open = 1'b0;
      end else begin
         idx = 15'((xi * MAX_DIM + yi) * MAX_DIM + zi);
         if (cell_checked[idx]) begin
            r.outcome = OUTCOME_CHECKED;
         end else begin
            ox = x[0];
            oy = y[0];
            oz = z[0];
            evens = int'(!ox) + int'(!oy) + int'(!oz);
            wall_inside = xi > 0 && xi + 1 < sx && yi > 0 && yi + 1 < sy
                          && zi > 0 && zi + 1 < sz;
            r.outcome = OUTCOME_SOLID;
            if (xi > 0 && yi > 0 && zi > 0 && evens == 0) begin
               cell_solid[idx] = 1'b0;
               r.outcome = OUTCOME_SPACE;
            end else if (wall_inside && evens == 1) begin
               stride = !ox ? STEP_X : (!oy ? STEP_Y : STEP_Z);
               root_near = chase_root(15'(int'(idx) - stride));
               root_far  = chase_root(15'(int'(idx) + stride));
               if (root_near != root_far) begin
                  cell_parent[root_near] = root_far;
                  cell_linked[root_near] = 1'b1;
                  cell_solid[idx] = 1'b0;
                  r.outcome = OUTCOME_WALL_OPENED;
               end else begin
                  r.outcome = OUTCOME_WALL_KEPT;
               end
            end
            cell_checked[idx] = 1'b1;
            if (checked_count < 16'hFFFF) checked_count++;
         end
         r.cell_open = !cell_solid[idx];
      end
      r.remaining = REMAIN_W'((total > checked_count) ? total - checked_count : 0);
      return r;
   endfunction

   // -------------------------------------------------------------------------
   // coordinate pickers, bounded by the size in use
   // -------------------------------------------------------------------------
   function automatic coord_type any_coord(input int size);
      if (size == 0) return coord_type'($urandom);
      return coord_type'($urandom_range(0, size - 1));
   endfunction

   function automatic coord_type odd_coord(input int size);
      if (size < 2) return any_coord(size);
      return coord_type'(2 * $urandom_range(0, (size - 2) / 2) + 1);
   endfunction

   function automatic coord_type even_coord(input int size);
      if (size == 0) return any_coord(size);
      return coord_type'(2 * $urandom_range(0, (size - 1) / 2));
   endfunction

   // -------------------------------------------------------------------------
   // request side
   // -------------------------------------------------------------------------
   // Offer one pick, hold it until accepted, then record what it should give.
   // Valid stays high afterwards so back-to-back requests need no extra edge.
   task automatic send_pick(input coord_type x, y, z);
      if (req_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(carve_predict(x, y, z));
   endtask

   // Mostly well-formed picks (rooms and walls inside the maze), some noise.
   task automatic send_random_pick();
      coord_type pos  [3];
      int        lim  [3];
      int        roll, axis;
      lim[0] = cfg_size_x;
      lim[1] = cfg_size_y;
      lim[2] = cfg_size_z;
      roll = $urandom_range(0, 99);
      axis = $urandom_range(0, 2);
      for (int a = 0; a < 3; a++) begin
         if (roll < 15)      pos[a] = coord_type'($urandom);
         else if (roll < 40) pos[a] = odd_coord(lim[a]);
         else if (roll < 90) pos[a] = (a == axis) ? even_coord(lim[a]) : odd_coord(lim[a]);
         else                pos[a] = any_coord(lim[a]);
      end
      send_pick(pos[0], pos[1], pos[2]);
   endtask

   // Drop valid and let every outstanding result come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all size registers plus the unused index, keeping valid high
   // across the four writes.
   task automatic set_sizes(input coord_type sx, sy, sz);
      coord_type value [4];
      value[REG_SIZE_X] = sx;
      value[REG_SIZE_Y] = sy;
      value[REG_SIZE_Z] = sz;
      value[REG_UNUSED] = coord_type'($urandom);
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_wdata <= value[i];
         do @(posedge clock); while (!csr_ready);
         case (CSR_INDEX_W'(i))
            REG_SIZE_X: cfg_size_x = value[i];
            REG_SIZE_Y: cfg_size_y = value[i];
            REG_SIZE_Z: cfg_size_z = value[i];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // tests
   // -------------------------------------------------------------------------
   // Basic rules at the reset sizes: solid, room, walls opened and kept,
   // repeat picks, edge walls and coordinates past the sizes.
   task automatic test_basic_rules();
      send_pick(5'd0,  5'd0,  5'd0);   // corner stays solid
      send_pick(5'd1,  5'd1,  5'd1);   // room opens
      send_pick(5'd2,  5'd1,  5'd1);   // x wall joins two fresh rooms
      send_pick(5'd1,  5'd1,  5'd1);   // already checked
      send_pick(5'd7,  5'd0,  5'd0);   // just past each size
      send_pick(5'd0,  5'd7,  5'd0);
      send_pick(5'd0,  5'd0,  5'd7);
      send_pick(5'd31, 5'd31, 5'd31);
      send_pick(5'd3,  5'd1,  5'd2);   // z wall, extends the chain
      send_pick(5'd2,  5'd1,  5'd3);   // x wall, third set merged in
      send_pick(5'd1,  5'd1,  5'd2);   // both sides share a root: kept
      send_pick(5'd2,  5'd2,  5'd1);   // two even coordinates
      send_pick(5'd6,  5'd1,  5'd1);   // wall on the outer face
      send_pick(5'd1,  5'd2,  5'd1);   // y wall
   endtask

   // Size edges: zero, largest, even and one, with the remaining count
   // floored once the checked total exceeds the maze.
   task automatic test_size_edges();
      wait_idle();
      set_sizes(5'd0, 5'd7, 5'd7);
      send_pick(5'd0, 5'd0, 5'd0);
      wait_idle();
      set_sizes(5'd31, 5'd31, 5'd31);
      send_pick(5'd30, 5'd30, 5'd30);
      send_pick(5'd29, 5'd29, 5'd29);
      send_pick(5'd30, 5'd29, 5'd29);
      send_pick(5'd28, 5'd29, 5'd29);
      wait_idle();
      set_sizes(5'd6, 5'd6, 5'd6);
      send_pick(5'd4, 5'd1, 5'd1);
      send_pick(5'd5, 5'd5, 5'd5);
      wait_idle();
      set_sizes(5'd1, 5'd1, 5'd1);
      send_pick(5'd0, 5'd0, 5'd0);
      send_pick(5'd1, 5'd0, 5'd0);
   endtask

   task automatic test_random_carving(input coord_type sx, sy, sz, input int count);
      wait_idle();
      set_sizes(sx, sy, sz);
      for (int k = 0; k < count; k++) send_random_pick();
   endtask

   // Hold results off for a long stretch while requests keep coming, so the
   // block fills and pushes back on its request side.
   task automatic test_backpressure();
      wait_idle();
      set_sizes(5'd13, 5'd13, 5'd13);
      fork
         begin : hold_off
            stall_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            stall_hold <= 1'b0;
         end
         begin : offer
            for (int k = 0; k < 20; k++) send_random_pick();
         end
      join
   endtask

   // Closing stretch with no gaps and no stalls on either side; switch the
   // gaps off first so that a running stall burst drains while idle.
   task automatic test_final_no_idle();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      wait_idle();
      set_sizes(5'd17, 5'd19, 5'd21);
      for (int k = 0; k < 100; k++) send_random_pick();
   endtask

   // -------------------------------------------------------------------------
   // result side: random stall bursts, each ended by a countdown over clock cycles
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (burst_left != 0) begin
         burst_left <= burst_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 5) == 0) begin
         stall_burst <= 1'b1;
         burst_left  <= $urandom_range(0, 7);
      end else begin
         stall_burst <= 1'b0;
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_check
      carve_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            if (fail_count < REPORT_LIMIT)
               $display("unexpected result: outcome %0d open %0d remaining %0d",
                        rsp_outcome, rsp_cell_open, rsp_remaining);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_outcome !== want.outcome || rsp_cell_open !== want.cell_open
                || rsp_remaining !== want.remaining) begin
               if (fail_count < REPORT_LIMIT)
                  $display({"mismatch at pick (%0d,%0d,%0d): outcome %0d/%0d",
                            " open %0d/%0d remaining %0d/%0d (expected/actual)"},
                           want.pick_x, want.pick_y, want.pick_z,
                           want.outcome, rsp_outcome, want.cell_open, rsp_cell_open,
                           want.remaining, rsp_remaining);
               fail_count++;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // sequence of tests
   // -------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_basic_rules();
      test_size_edges();
      test_random_carving(5'd9, 5'd9, 5'd9, 120);
      test_random_carving(5'd15, 5'd13, 5'd11, 150);
      test_random_carving(5'd10, 5'd8, 5'd12, 80);
      test_random_carving(5'd3, 5'd31, 5'd5, 60);
      test_backpressure();
      test_random_carving(5'd31, 5'd31, 5'd31, 80);
      test_final_no_idle();
      wait_idle();
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Stop a hung run: allows the clearing pass and long chain walks many
   // times over.
   initial begin
      #10000000;
      $display("status: fail");
      $finish;
   end

endmodule
